// File: rtl/assert_macros.svh
// Assertion helpers used by the cipher unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property holds in the same cycle as its trigger.
`define KBSC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kbsc assertion failed");

// Property holds in the cycle after its trigger.
`define KBSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kbsc assertion failed");

`else

`define KBSC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define KBSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/kbsc_pkg.sv
`default_nettype none

package kbsc_pkg;

	typedef logic [31:0] word_t;
	typedef logic [3:0][31:0] key_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_KEY0    = 3'd0,
		CFG_KEY1    = 3'd1,
		CFG_KEY2    = 3'd2,
		CFG_KEY3    = 3'd3,
		CFG_DECRYPT = 3'd4,
		CFG_BORDER  = 3'd5
	} cfg_index_t;

	localparam word_t CHAIN_SEED = 32'h1D84D2EF;
	localparam word_t STEP_A     = 32'd36717559;
	localparam word_t STEP_B     = 32'd39880843;
	localparam word_t STEP_C     = 32'd52692169;
	localparam word_t STEP_AB    = STEP_A + STEP_B;
	localparam word_t STEP_ABC   = STEP_A + STEP_B + STEP_C;

	// Per-byte control handed to the byte transform
	typedef struct packed {
		logic       decrypt;
		logic [1:0] border;
		logic [1:0] pos;
	} xform_ctrl_t;

	// Position bookkeeping returned by the byte transform
	typedef struct packed {
		logic [1:0] border;
		logic [1:0] pos;
	} xform_stat_t;

	function automatic word_t sext8(input logic [7:0] b);
		sext8 = {{24{b[7]}}, b};
	endfunction

	function automatic word_t pick_word(input key_t k, input logic [1:0] sel);
		word_t w;
		unique case (sel)
			2'd0: w = k[0];
			2'd1: w = k[1];
			2'd2: w = k[2];
			default: w = k[3];
		endcase
		pick_word = w;
	endfunction

endpackage

`default_nettype wire

// File: rtl/kbsc_key_round.sv
`default_nettype none

module kbsc_key_round (
	input  kbsc_pkg::key_t  key_in,
	input  kbsc_pkg::word_t seed,
	output kbsc_pkg::key_t  key_out
);

	kbsc_pkg::word_t x0, x1, x2, x3;
	kbsc_pkg::word_t t0, t1, t2, t3;
	kbsc_pkg::word_t k0n;

	// Mix word 0 with word 1 and the seed
	assign x0  = key_in[1] ^ seed;
	assign t0  = key_in[0] ^ x0;
	assign k0n = {t0[26:0], t0[31:27]} + x0;

	// Mix word 1 with word 2
	assign x1 = key_in[2] - (seed + kbsc_pkg::STEP_A);
	assign t1 = key_in[1] ^ x1;

	// Mix word 2 with word 3
	assign x2 = key_in[3] ^ (seed + kbsc_pkg::STEP_AB);
	assign t2 = key_in[2] ^ x2;

	// Mix word 3 with the fresh word 0
	assign x3 = k0n + (seed + kbsc_pkg::STEP_ABC);
	assign t3 = key_in[3] ^ x3;

	assign key_out[0] = k0n;
	assign key_out[1] = {t1[8:0], t1[31:9]} + x1;
	assign key_out[2] = {t2[24:0], t2[31:25]} + x2;
	assign key_out[3] = {t3[12:0], t3[31:13]} + x3;

endmodule

`default_nettype wire

// File: rtl/kbsc_byte_xform.sv
`default_nettype none

module kbsc_byte_xform (
	input  kbsc_pkg::xform_ctrl_t ctrl,
	input  logic [7:0]            in_byte,
	input  kbsc_pkg::key_t        key,
	input  kbsc_pkg::word_t       chain,
	output logic [7:0]            out_byte,
	output kbsc_pkg::word_t       chain_next,
	output kbsc_pkg::xform_stat_t stat
);

	kbsc_pkg::word_t x;
	kbsc_pkg::word_t o;
	kbsc_pkg::word_t c;
	kbsc_pkg::word_t r4;
	kbsc_pkg::word_t k_pos;
	kbsc_pkg::word_t k_mir;
	kbsc_pkg::word_t k_chn;
	logic [1:0]      border_dec;

	assign x     = kbsc_pkg::sext8(in_byte);
	assign r4    = {chain[27:0], 4'b0000};
	assign k_pos = kbsc_pkg::pick_word(key, ctrl.pos);
	assign k_mir = kbsc_pkg::pick_word(key, ~ctrl.pos);
	assign k_chn = kbsc_pkg::pick_word(key, chain[1:0]);
	assign border_dec = ctrl.border - 2'd1;

	// Transform the byte and fold it into the chain
	always_comb begin
		o          = '0;
		chain_next = '0;
		stat       = '0;
		if (ctrl.border != 2'd0) begin
			if (ctrl.decrypt) begin
				o = (x ^ k_mir) - k_pos;
			end else begin
				o = (x + k_pos) ^ k_mir;
			end
			chain_next  = (r4 + c) ^ k_chn;
			stat.border = border_dec;
			stat.pos    = (border_dec == 2'd0) ? 2'd0 : ctrl.pos + 2'd1;
		end else begin
			unique case (ctrl.pos)
				2'd0: begin
					o = ctrl.decrypt ? (x ^ key[1]) - chain - key[0]
						: (x + chain + key[0]) ^ key[1];
					chain_next = (r4 - c) ^ key[3];
				end
				2'd1: begin
					o = ctrl.decrypt ? (x ^ key[2]) + chain - key[1]
						: (x - chain + key[1]) ^ key[2];
					chain_next = (r4 + c) - key[2];
				end
				2'd2: begin
					o = ctrl.decrypt ? (x ^ key[3]) - chain + key[2]
						: (x + chain - key[2]) ^ key[3];
					chain_next = (r4 - c) ^ key[1];
				end
				default: begin
					o = ctrl.decrypt ? (x ^ key[0]) + chain + key[3]
						: (x - chain - key[3]) ^ key[0];
					chain_next = (r4 + c) + key[0];
				end
			endcase
			stat.border = 2'd0;
			stat.pos    = ctrl.pos + 2'd1;
		end
	end

	// Chain takes the ciphertext byte in either direction
	assign c        = ctrl.decrypt ? x : kbsc_pkg::sext8(o[7:0]);
	assign out_byte = o[7:0];

endmodule

`default_nettype wire

// File: rtl/keyed_byte_stream_cipher_unit.sv
// Channel  | Direction | Handshake          | Payload
// input    | in        | in_valid/in_ready   | in_byte, message_start
// output   | out       | out_valid/out_ready | out_byte
// config   | in        | cfg_write           | cfg_index, cfg_data
//
// One byte per cycle unless the output stalls; beats pass input and output registers.
// The rate is set by the combinational loop through key mixing, byte transform and
// chain update, which feeds the next byte.
// Reset clears configuration, working key, chain and position state to zero.
// A stalled output holds its beat; the input register keeps one beat waiting behind it.
`default_nettype none

module keyed_byte_stream_cipher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        message_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	`include "assert_macros.svh"

	// Configuration registers
	kbsc_pkg::key_t  cfg_key_q;
	logic            decrypt_q;
	logic [1:0]      border_cfg_q;

	// Cipher state
	kbsc_pkg::key_t  key_q;
	kbsc_pkg::word_t chain_q;
	logic [1:0]      border_q;
	logic [1:0]      pos_q;

	// Input register
	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            start_s1;

	// Output register
	logic            out_valid_q;
	logic [7:0]      out_byte_q;

	logic                  advance;
	kbsc_pkg::key_t        key_eff;
	kbsc_pkg::key_t        key_mixed;
	kbsc_pkg::key_t        key_use;
	kbsc_pkg::word_t       chain_eff;
	kbsc_pkg::word_t       chain_next;
	kbsc_pkg::xform_ctrl_t ctrl;
	kbsc_pkg::xform_stat_t stat;
	logic [7:0]            xform_byte;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_key_q    <= '0;
			decrypt_q    <= 1'b0;
			border_cfg_q <= 2'd0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				kbsc_pkg::CFG_KEY0:    cfg_key_q[0] <= cfg_data;
				kbsc_pkg::CFG_KEY1:    cfg_key_q[1] <= cfg_data;
				kbsc_pkg::CFG_KEY2:    cfg_key_q[2] <= cfg_data;
				kbsc_pkg::CFG_KEY3:    cfg_key_q[3] <= cfg_data;
				kbsc_pkg::CFG_DECRYPT: decrypt_q    <= cfg_data[0];
				kbsc_pkg::CFG_BORDER:  border_cfg_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Advance when the output register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Capture the input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= in_byte;
			start_s1 <= message_start;
		end
	end

	// Reload state at message start
	assign key_eff   = start_s1 ? cfg_key_q : key_q;
	assign chain_eff = start_s1 ? (kbsc_pkg::CHAIN_SEED ^ cfg_key_q[0]) : chain_q;
	assign ctrl.decrypt = decrypt_q;
	assign ctrl.border  = start_s1 ? border_cfg_q : border_q;
	assign ctrl.pos     = start_s1 ? 2'd0 : pos_q;

	kbsc_key_round u_round (
		.key_in  (key_eff),
		.seed    (chain_eff),
		.key_out (key_mixed)
	);

	// Mix the key at the head of a border run or a group
	assign key_use = (ctrl.pos == 2'd0) ? key_mixed : key_eff;

	kbsc_byte_xform u_xform (
		.ctrl       (ctrl),
		.in_byte    (byte_s1),
		.key        (key_use),
		.chain      (chain_eff),
		.out_byte   (xform_byte),
		.chain_next (chain_next),
		.stat       (stat)
	);

	// Update cipher state once per processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q    <= '0;
			chain_q  <= '0;
			border_q <= 2'd0;
			pos_q    <= 2'd0;
		end else if (advance) begin
			key_q    <= key_use;
			chain_q  <= chain_next;
			border_q <= stat.border;
			pos_q    <= stat.pos;
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= xform_byte;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;

	`KBSC_ASSERT_SAME(a_border_pos, clk, arst_n, border_q != 2'd0, pos_q != 2'd3)
	`KBSC_ASSERT_NEXT(a_state_hold, clk, arst_n, !advance, $stable(chain_q) && $stable(key_q))
	`KBSC_ASSERT_NEXT(a_result_shown, clk, arst_n, advance, out_valid_q)
	`KBSC_ASSERT_NEXT(a_border_count, clk, arst_n,
		advance && !start_s1 && border_q != 2'd0, border_q == $past(border_q) - 2'd1)

endmodule

`default_nettype wire

// File: tb/sv/keyed_byte_stream_cipher_checker.sv
`default_nettype none

module keyed_byte_stream_cipher_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        message_start,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  out_byte,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int unsigned fail_count,
	output int unsigned pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	// Register copies as written through the config port
	kbsc_pkg::key_t  key_reg;
	logic            decrypt_reg;
	logic [1:0]      border_reg;

	// Running cipher state
	kbsc_pkg::key_t  run_key;
	kbsc_pkg::word_t chain;
	logic [1:0]      border_left;
	logic [1:0]      grp_pos;

	logic [7:0]  expected_bytes[$];
	logic [7:0]  want;
	int unsigned miss_total;

	function automatic kbsc_pkg::word_t rotl(input kbsc_pkg::word_t v, input int unsigned s);
		rotl = (v << s) | (v >> (32 - s));
	endfunction

	function automatic kbsc_pkg::word_t mix(input kbsc_pkg::word_t w,
		input kbsc_pkg::word_t x, input int unsigned s);
		mix = rotl(w ^ x, s) + x;
	endfunction

	function automatic kbsc_pkg::word_t widen(input logic [7:0] b);
		widen = kbsc_pkg::word_t'($signed(b));
	endfunction

	// One key-mixing round seeded by the chain
	function automatic void mix_round(input kbsc_pkg::word_t seed);
		kbsc_pkg::word_t r;
		r = seed;
		run_key[0] = mix(run_key[0], run_key[1] ^ r, 5);
		r += kbsc_pkg::STEP_A;
		run_key[1] = mix(run_key[1], run_key[2] - r, 23);
		r += kbsc_pkg::STEP_B;
		run_key[2] = mix(run_key[2], run_key[3] ^ r, 7);
		r += kbsc_pkg::STEP_C;
		run_key[3] = mix(run_key[3], run_key[0] + r, 19);
	endfunction

	// Transform one byte and advance key, chain and position
	function automatic logic [7:0] transform_byte(input logic [7:0] b, input logic start);
		kbsc_pkg::word_t x;
		kbsc_pkg::word_t r;
		kbsc_pkg::word_t c;
		kbsc_pkg::word_t o;
		logic [1:0]      p;
		x = widen(b);
		if (start) begin
			run_key     = key_reg;
			chain       = kbsc_pkg::CHAIN_SEED ^ key_reg[0];
			border_left = border_reg;
			grp_pos     = 2'd0;
		end
		p = grp_pos;
		if (p == 2'd0)
			mix_round(chain);
		r = chain;
		if (border_left != 2'd0) begin
			// leading border bytes share one formula
			if (decrypt_reg) begin
				c = x;
				o = (x ^ run_key[2'd3 - p]) - run_key[p];
			end else begin
				o = (x + run_key[p]) ^ run_key[2'd3 - p];
				c = widen(o[7:0]);
			end
			chain       = ((r << 4) + c) ^ run_key[r[1:0]];
			border_left = border_left - 2'd1;
			grp_pos     = (border_left == 2'd0) ? 2'd0 : p + 2'd1;
		end else begin
			if (decrypt_reg) begin
				c = x;
				case (p)
					2'd0: o = (x ^ run_key[1]) - r - run_key[0];
					2'd1: o = (x ^ run_key[2]) + r - run_key[1];
					2'd2: o = (x ^ run_key[3]) - r + run_key[2];
					default: o = (x ^ run_key[0]) + r + run_key[3];
				endcase
			end else begin
				case (p)
					2'd0: o = (x + r + run_key[0]) ^ run_key[1];
					2'd1: o = (x - r + run_key[1]) ^ run_key[2];
					2'd2: o = (x + r - run_key[2]) ^ run_key[3];
					default: o = (x - r - run_key[3]) ^ run_key[0];
				endcase
				c = widen(o[7:0]);
			end
			case (p)
				2'd0: chain = ((r << 4) - c) ^ run_key[3];
				2'd1: chain = ((r << 4) + c) - run_key[2];
				2'd2: chain = ((r << 4) - c) ^ run_key[1];
				default: chain = ((r << 4) + c) + run_key[0];
			endcase
			grp_pos = p + 2'd1;
		end
		transform_byte = o[7:0];
	endfunction

	// Track config writes, predict each input beat, check each output beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_reg       = '0;
			decrypt_reg   = 1'b0;
			border_reg    = 2'd0;
			run_key       = '0;
			chain         = '0;
			border_left   = 2'd0;
			grp_pos       = 2'd0;
			miss_total    = 0;
			expected_bytes.delete();
			fail_count    <= 0;
			pending_count <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					kbsc_pkg::CFG_KEY0:    key_reg[0] = cfg_data;
					kbsc_pkg::CFG_KEY1:    key_reg[1] = cfg_data;
					kbsc_pkg::CFG_KEY2:    key_reg[2] = cfg_data;
					kbsc_pkg::CFG_KEY3:    key_reg[3] = cfg_data;
					kbsc_pkg::CFG_DECRYPT: decrypt_reg = cfg_data[0];
					kbsc_pkg::CFG_BORDER:  border_reg = cfg_data[1:0];
					// drop writes to unused indexes
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_bytes.size() == 0) begin
					if (miss_total < 10)
						$display("out_byte %02h with nothing expected", out_byte);
					miss_total++;
				end else begin
					want = expected_bytes.pop_front();
					if (out_byte !== want) begin
						if (miss_total < 10)
							$display("out_byte expected %02h got %02h", want, out_byte);
						miss_total++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_bytes.push_back(transform_byte(in_byte, message_start));
			fail_count    <= miss_total;
			pending_count <= expected_bytes.size();
		end
	end

endmodule

`default_nettype wire

// File: tb/sv/tb_keyed_byte_stream_cipher_unit.sv
`default_nettype none

module tb_keyed_byte_stream_cipher_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          PHASES          = 12;
	localparam int          BEATS_PER_PHASE = 156;
	localparam int          HOLD_CYCLES     = 60;
	localparam int unsigned WATCHDOG_LIMIT  = 2000;
	localparam logic [2:0]  CFG_SPARE_LO    = 3'd6;
	localparam logic [2:0]  CFG_SPARE_HI    = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = 8'h00;
	logic        message_start = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        cfg_write = 1'b0;
	logic [2:0]  cfg_index = 3'd0;
	logic [31:0] cfg_data = 32'h0;

	int unsigned fail_count;
	int unsigned pending_count;
	int unsigned send_idle_pct = 35;
	int unsigned recv_idle_pct = 87;
	int unsigned hold_asked = 0;
	int unsigned hold_done = 0;
	int unsigned quiet_cycles = 0;

	always #1 clk = ~clk;

	keyed_byte_stream_cipher_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_byte       (in_byte),
		.message_start (message_start),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	keyed_byte_stream_cipher_checker cipher_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_byte       (in_byte),
		.message_start (message_start),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	// Receiver: random stalls, or a long hold-off when one is asked for
	initial begin
		forever begin
			@(posedge clk);
			if (hold_done != hold_asked) begin
				hold_done = hold_asked;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: end the run when no beat moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("keyed_byte_stream_cipher_unit: mismatch");
				$finish;
			end
		end
	end

	// Offer one input beat and hold it until accepted
	task automatic send_byte(input logic [7:0] b, input logic start);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		in_byte       <= b;
		message_start <= start;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop offering and wait until every predicted byte has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (4) @(posedge clk);
	endtask

	// Drive one register write; the caller drops cfg_write afterwards
	task automatic write_reg(input logic [2:0] idx, input kbsc_pkg::word_t d);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
	endtask

	task automatic load_settings(input kbsc_pkg::key_t k, input logic dec, input logic [1:0] bc);
		kbsc_pkg::word_t junk;
		junk = $urandom();
		write_reg(kbsc_pkg::CFG_KEY0, k[0]);
		write_reg(kbsc_pkg::CFG_KEY1, k[1]);
		write_reg(kbsc_pkg::CFG_KEY2, k[2]);
		write_reg(kbsc_pkg::CFG_KEY3, k[3]);
		write_reg(kbsc_pkg::CFG_DECRYPT, {junk[31:1], dec});
		write_reg(kbsc_pkg::CFG_BORDER, {junk[31:2], bc});
		cfg_write <= 1'b0;
	endtask

	// Key word with the extremes drawn often
	function automatic kbsc_pkg::word_t draw_key_word();
		case ($urandom_range(0, 7))
			0: draw_key_word = 32'h0000_0000;
			1: draw_key_word = 32'hFFFF_FFFF;
			default: draw_key_word = $urandom();
		endcase
	endfunction

	initial begin
		int              phase;
		int              sent;
		int              len;
		int              n;
		int              i;
		kbsc_pkg::key_t  k;
		logic            dec;
		logic [1:0]      bc;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// No message start yet: zero key, group mode
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		wait_drained();

		// Three border bytes then a full group, byte extremes
		load_settings({4{32'hFFFF_FFFF}}, 1'b0, 2'd3);
		send_byte(8'h7F, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'hFE, 1'b0);
		send_byte(8'h55, 1'b0);
		wait_drained();

		// Mid-message: decrypt switches at once, the new key waits for a start,
		// unused indexes are ignored
		write_reg(kbsc_pkg::CFG_DECRYPT, 32'h0000_0001);
		write_reg(kbsc_pkg::CFG_KEY0, 32'h0000_0000);
		write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
		write_reg(CFG_SPARE_HI, 32'hA5A5_5A5A);
		cfg_write <= 1'b0;
		send_byte(8'hAA, 1'b0);
		send_byte(8'h33, 1'b0);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h3C, 1'b0);
		wait_drained();

		// One border byte in decrypt mode
		load_settings({32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000},
			1'b1, 2'd1);
		send_byte(8'h80, 1'b1);
		send_byte(8'h7F, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h10, 1'b0);
		wait_drained();

		// Restart inside the border, then back-to-back starts
		load_settings({32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h1234_5678},
			1'b0, 2'd2);
		send_byte(8'h40, 1'b1);
		send_byte(8'hBF, 1'b0);
		send_byte(8'h01, 1'b1);
		send_byte(8'hFE, 1'b1);
		send_byte(8'h01, 1'b1);

		for (phase = 0; phase < PHASES; phase++) begin
			wait_drained();
			if (phase == 0) begin
				k   = '0;
				dec = 1'b0;
				bc  = 2'd0;
			end else if (phase == 1) begin
				k   = {4{32'hFFFF_FFFF}};
				dec = 1'b1;
				bc  = 2'd3;
			end else begin
				for (i = 0; i < 4; i++)
					k[i] = draw_key_word();
				dec = 1'($urandom_range(0, 1));
				bc  = 2'($urandom_range(0, 3));
			end
			load_settings(k, dec, bc);
			if (phase == 4) begin
				send_idle_pct = 87;
				recv_idle_pct = 35;
			end else if (phase == 8) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// long receiver hold-off while the sender keeps offering
			if (phase == 2 || phase == 10)
				hold_asked++;
			sent = 0;
			while (sent < BEATS_PER_PHASE) begin
				if ($urandom_range(0, 9) < 8) begin
					// well-formed message, length mostly matching the border count
					len = $urandom_range(0, 6) * 4;
					len += ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : bc;
					if (len == 0)
						len = 4;
					for (i = 0; i < len; i++)
						send_byte(8'($urandom_range(0, 255)), i == 0);
					sent += len;
				end else begin
					// loose bytes with stray start marks
					n = $urandom_range(1, 8);
					for (i = 0; i < n; i++)
						send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
					sent += n;
				end
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("keyed_byte_stream_cipher_unit: match");
		end else begin
			$display("keyed_byte_stream_cipher_unit: mismatch");
		end
		$finish;
	end

endmodule

`default_nettype wire
